/* hw/rtl/rsvc_pkg.sv */
package rsvc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned GainW  = 24;
  localparam int unsigned MinRW  = 16;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned SumW   = 2 * CoordW;      // x^2+y^2+z^2, Q32.32
  localparam int unsigned RadW   = CoordW;          // radius, Q16.16
  localparam int unsigned Rad2W  = RadW + 16;       // radius widened by 2^16
  localparam int unsigned SRootW = Rad2W / 2;       // square root of radius
  localparam int unsigned ProdW  = GainW + SRootW;  // gain * sqrt(r)
  localparam int unsigned KW     = 32;              // scale factor, Q16.16
  localparam int unsigned MulW   = CoordW + KW;
  localparam int unsigned PW     = MulW - 16;       // rounded product

  typedef enum logic [0:0] {
    REG_SCALE_GAIN = 1'b0,
    REG_MIN_RADIUS = 1'b1
  } reg_idx_e;

  // Sideband that travels with every item down the pipe.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              last;
    logic              scaled;
  } side_t;

  function automatic logic [CoordW-1:0] mag32(logic [CoordW-1:0] v);
    return v[CoordW-1] ? (~v + CoordW'(1)) : v;
  endfunction

  // Restore the sign and clamp to the signed 32-bit range.
  function automatic logic [CoordW-1:0] sat_coord(logic neg, logic [PW-1:0] p);
    logic [CoordW-1:0] res;
    if (neg) begin
      if (p >= PW'(64'h8000_0000)) res = 32'h8000_0000;
      else res = ~p[CoordW-1:0] + CoordW'(1);
    end else begin
      if (p > PW'(64'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
      else res = p[CoordW-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/radial_sqrt_vertex_compress.sv */
// A result passes through every stage, most of them in the two bit-per-stage square roots
//   (32 + 24 stages) and in the 32-stage divider.
// Throughput: one item per cycle; busy stays low, so start may be held high every cycle.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears all stage valid bits and loads
//   scale_gain = 3.0 and min_radius = 66; no clearing pass is needed.
module radial_sqrt_vertex_compress
  import rsvc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic                     in_last_i,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic signed [CoordW-1:0] out_z_o,
  output logic                     was_scaled_o,
  output logic                     out_last_o
);

  localparam int unsigned Sq1N = RadW;    // steps of the radius square root
  localparam int unsigned Sq2N = SRootW;  // steps of the sqrt(r) square root
  localparam int unsigned DivN = KW;      // quotient bits of the divider
  localparam int unsigned Rem1W = RadW + 2;
  localparam int unsigned Rem2W = SRootW + 2;

  // The pipeline never holds an item back.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- config
  logic [GainW-1:0] gain_q;
  logic [MinRW-1:0] minr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainW'(196608);
      minr_q <= MinRW'(66);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SCALE_GAIN: gain_q <= cfg_data_i[GainW-1:0];
        REG_MIN_RADIUS: minr_q <= cfg_data_i[MinRW-1:0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_acc = start && !busy;

  // ------------------------------------------- stage A: capture, magnitudes
  logic              a_v_q;
  side_t             a_side_q;
  logic [CoordW-1:0] a_mx_q, a_my_q, a_mz_q;

  // ------------------------------------------------------ stage B: squares
  logic              b_v_q;
  side_t             b_side_q;
  logic [SumW-1:0]   b_sx_q, b_sy_q, b_sz_q;

  // --------------------------------------------------- stage C: first add
  logic              c_v_q;
  side_t             c_side_q;
  logic [SumW-1:0]   c_sxy_q, c_sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      a_v_q <= in_acc;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q <= '{x: pos_x_i, y: pos_y_i, z: pos_z_i, last: in_last_i, scaled: 1'b0};
    a_mx_q   <= mag32(pos_x_i);
    a_my_q   <= mag32(pos_y_i);
    a_mz_q   <= mag32(pos_z_i);
    b_side_q <= a_side_q;
    b_sx_q   <= SumW'(a_mx_q) * SumW'(a_mx_q);
    b_sy_q   <= SumW'(a_my_q) * SumW'(a_my_q);
    b_sz_q   <= SumW'(a_mz_q) * SumW'(a_mz_q);
    c_side_q <= b_side_q;
    c_sxy_q  <= b_sx_q + b_sy_q;
    c_sz_q   <= b_sz_q;
  end

  // ------------------------------------- radius square root, 1 bit a stage
  // Stage D (index 0) holds the full sum of squares.
  logic [Sq1N:0]     s1_v_q;
  side_t             s1_side_q [Sq1N+1];
  logic [SumW-1:0]   s1_rad_q  [Sq1N+1];
  logic [Rem1W-1:0]  s1_rem_q  [Sq1N+1];
  logic [RadW-1:0]   s1_root_q [Sq1N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q[0] <= 1'b0;
    else s1_v_q[0] <= c_v_q;
  end

  always_ff @(posedge clk_i) begin
    s1_side_q[0] <= c_side_q;
    s1_rad_q[0]  <= c_sxy_q + c_sz_q;
    s1_rem_q[0]  <= '0;
    s1_root_q[0] <= '0;
  end

  for (genvar i = 0; i < Sq1N; i++) begin : g_sq1
    logic [Rem1W+1:0] wide, trial;
    logic             fit;
    always_comb begin
      wide  = {s1_rem_q[i], s1_rad_q[i][SumW-1 -: 2]};
      trial = {2'b00, s1_root_q[i], 2'b01};
      fit   = wide >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) s1_v_q[i+1] <= 1'b0;
      else s1_v_q[i+1] <= s1_v_q[i];
    end
    always_ff @(posedge clk_i) begin
      s1_side_q[i+1] <= s1_side_q[i];
      s1_rad_q[i+1]  <= {s1_rad_q[i][SumW-3:0], 2'b00};
      s1_rem_q[i+1]  <= fit ? Rem1W'(wide - trial) : Rem1W'(wide);
      s1_root_q[i+1] <= {s1_root_q[i][RadW-2:0], fit};
    end
  end

  // ----------------------------- stage E: threshold, then sqrt(r * 2^16)
  logic [RadW-1:0] r_fin;
  side_t           e_side;
  assign r_fin = s1_root_q[Sq1N];
  always_comb begin
    e_side        = s1_side_q[Sq1N];
    e_side.scaled = r_fin > RadW'(minr_q);
  end

  logic [Sq2N:0]     s2_v_q;
  side_t             s2_side_q [Sq2N+1];
  logic [RadW-1:0]   s2_r_q    [Sq2N+1];
  logic [Rad2W-1:0]  s2_rad_q  [Sq2N+1];
  logic [Rem2W-1:0]  s2_rem_q  [Sq2N+1];
  logic [SRootW-1:0] s2_root_q [Sq2N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q[0] <= 1'b0;
    else s2_v_q[0] <= s1_v_q[Sq1N];
  end

  always_ff @(posedge clk_i) begin
    s2_side_q[0] <= e_side;
    s2_r_q[0]    <= r_fin;
    s2_rad_q[0]  <= {r_fin, 16'h0000};
    s2_rem_q[0]  <= '0;
    s2_root_q[0] <= '0;
  end

  for (genvar i = 0; i < Sq2N; i++) begin : g_sq2
    logic [Rem2W+1:0] wide, trial;
    logic             fit;
    always_comb begin
      wide  = {s2_rem_q[i], s2_rad_q[i][Rad2W-1 -: 2]};
      trial = {2'b00, s2_root_q[i], 2'b01};
      fit   = wide >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) s2_v_q[i+1] <= 1'b0;
      else s2_v_q[i+1] <= s2_v_q[i];
    end
    always_ff @(posedge clk_i) begin
      s2_side_q[i+1] <= s2_side_q[i];
      s2_r_q[i+1]    <= s2_r_q[i];
      s2_rad_q[i+1]  <= {s2_rad_q[i][Rad2W-3:0], 2'b00};
      s2_rem_q[i+1]  <= fit ? Rem2W'(wide - trial) : Rem2W'(wide);
      s2_root_q[i+1] <= {s2_root_q[i][SRootW-2:0], fit};
    end
  end

  // -------------------- stage F: gain * sqrt(r), then k = that / r
  // k stays below 2^32, so the upper product bits seed the remainder and
  // only 32 quotient bits are developed. The dividend register shifts the
  // quotient in from the bottom.
  logic [ProdW-1:0] f_prod;
  assign f_prod = ProdW'(gain_q) * ProdW'(s2_root_q[Sq2N]);

  logic [DivN:0]     dv_v_q;
  side_t             dv_side_q [DivN+1];
  logic [RadW-1:0]   dv_r_q    [DivN+1];
  logic [RadW-1:0]   dv_rem_q  [DivN+1];
  logic [KW-1:0]     dv_num_q  [DivN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else dv_v_q[0] <= s2_v_q[Sq2N];
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= s2_side_q[Sq2N];
    dv_r_q[0]    <= s2_r_q[Sq2N];
    dv_rem_q[0]  <= RadW'(f_prod[ProdW-1:KW]);
    dv_num_q[0]  <= f_prod[KW-1:0];
  end

  for (genvar i = 0; i < DivN; i++) begin : g_div
    logic [RadW:0] wide;
    logic          fit;
    always_comb begin
      wide = {dv_rem_q[i], dv_num_q[i][KW-1]};
      fit  = wide >= {1'b0, dv_r_q[i]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[i+1] <= 1'b0;
      else dv_v_q[i+1] <= dv_v_q[i];
    end
    always_ff @(posedge clk_i) begin
      dv_side_q[i+1] <= dv_side_q[i];
      dv_r_q[i+1]    <= dv_r_q[i];
      dv_rem_q[i+1]  <= fit ? RadW'(wide - {1'b0, dv_r_q[i]}) : RadW'(wide);
      dv_num_q[i+1]  <= {dv_num_q[i][KW-2:0], fit};
    end
  end

  // ------------- stage M: magnitudes, G: products, O1: round, O2: output
  logic              m_v_q, g_v_q, o1_v_q;
  side_t             m_side_q, g_side_q, o1_side_q;
  logic [KW-1:0]     m_k_q;
  logic [CoordW-1:0] m_mx_q, m_my_q, m_mz_q;
  logic [MulW-1:0]   g_px_q, g_py_q, g_pz_q;
  logic [PW-1:0]     o1_px_q, o1_py_q, o1_pz_q;
  side_t             dv_out;

  assign dv_out = dv_side_q[DivN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q  <= 1'b0;
      g_v_q  <= 1'b0;
      o1_v_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      m_v_q  <= dv_v_q[DivN];
      g_v_q  <= m_v_q;
      o1_v_q <= g_v_q;
      done_o <= o1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_side_q  <= dv_out;
    m_k_q     <= dv_num_q[DivN];
    m_mx_q    <= mag32(dv_out.x);
    m_my_q    <= mag32(dv_out.y);
    m_mz_q    <= mag32(dv_out.z);
    g_side_q  <= m_side_q;
    g_px_q    <= MulW'(m_mx_q) * MulW'(m_k_q);
    g_py_q    <= MulW'(m_my_q) * MulW'(m_k_q);
    g_pz_q    <= MulW'(m_mz_q) * MulW'(m_k_q);
    o1_side_q <= g_side_q;
    o1_px_q   <= PW'((g_px_q + MulW'(32768)) >> 16);
    o1_py_q   <= PW'((g_py_q + MulW'(32768)) >> 16);
    o1_pz_q   <= PW'((g_pz_q + MulW'(32768)) >> 16);
    // Pass the vertex through untouched when it sat inside the threshold.
    out_x_o      <= o1_side_q.scaled ? sat_coord(o1_side_q.x[CoordW-1], o1_px_q)
                                     : o1_side_q.x;
    out_y_o      <= o1_side_q.scaled ? sat_coord(o1_side_q.y[CoordW-1], o1_py_q)
                                     : o1_side_q.y;
    out_z_o      <= o1_side_q.scaled ? sat_coord(o1_side_q.z[CoordW-1], o1_pz_q)
                                     : o1_side_q.z;
    was_scaled_o <= o1_side_q.scaled;
    out_last_o   <= o1_side_q.last;
  end

  // ------------------------------------------------------------ checks
  // Square root remainders never exceed twice the root.
  a_sq1_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q[Sq1N] |-> (s1_rem_q[Sq1N] <= {1'b0, s1_root_q[Sq1N], 1'b0}))
    else $error("radius square root remainder too large");

  a_sq2_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q[Sq2N] |-> (s2_rem_q[Sq2N] <= {1'b0, s2_root_q[Sq2N], 1'b0}))
    else $error("sqrt(r) remainder too large");

  // A scaled item has a nonzero radius and a division remainder below it.
  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DivN] && dv_side_q[DivN].scaled) |->
      (dv_r_q[DivN] != '0 && dv_rem_q[DivN] < dv_r_q[DivN]))
    else $error("divider remainder not below radius");

endmodule

/* dv/radial_sqrt_vertex_compress_test.sv */
module radial_sqrt_vertex_compress_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rsvc_pkg::*;

  // One vertex as it leaves the block.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        scaled;
    logic        last;
  } vertex_t;

  // Predicts the compressed vertex for every accepted item and holds the
  // predictions in order until the block delivers them.
  class vertex_scoreboard;
    logic [23:0] gain;
    logic [15:0] min_r;
    vertex_t     pending[$];
    int          errors;
    int          checked;
    int          scaled_seen;

    function new();
      gain  = 24'd196608;
      min_r = 16'd66;
    endfunction

    function void set_reg(reg_idx_e idx, logic [23:0] data);
      case (idx)
        REG_SCALE_GAIN: gain = data;
        REG_MIN_RADIUS: min_r = data[15:0];
        default: ;
      endcase
    endfunction

    // Floor square root, one result bit per pass.
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned acc;
      longint unsigned bitv;
      acc  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= acc + bitv) begin
          v   = v - (acc + bitv);
          acc = (acc >> 1) + bitv;
        end else begin
          acc = acc >> 1;
        end
        bitv = bitv >> 2;
      end
      return acc;
    endfunction

    function longint unsigned magnitude(logic [31:0] c);
      return c[31] ? ((64'd1 << 32) - {32'd0, c}) : {32'd0, c};
    endfunction

    // Round the scaled magnitude half up, restore the sign, clamp to 32 bits.
    function logic [31:0] scale_coord(logic [31:0] c, longint unsigned k);
      longint unsigned p;
      p = (magnitude(c) * k + 64'd32768) >> 16;
      if (c[31]) begin
        if (p >= 64'h8000_0000) return 32'h8000_0000;
        return 32'(-p);
      end
      if (p > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return p[31:0];
    endfunction

    function void note_item(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      longint unsigned ax, ay, az, radius, root, k;
      vertex_t v;
      ax = magnitude(x);
      ay = magnitude(y);
      az = magnitude(z);
      radius = root_floor(ax * ax + ay * ay + az * az);
      v.last = last;
      if (radius > min_r) begin
        root = root_floor(radius << 16);
        k = (longint'(gain) * root) / radius;
        v.x = scale_coord(x, k);
        v.y = scale_coord(y, k);
        v.z = scale_coord(z, k);
        v.scaled = 1'b1;
      end else begin
        v.x = x;
        v.y = y;
        v.z = z;
        v.scaled = 1'b0;
      end
      pending.push_back(v);
    endfunction

    function void check_result(vertex_t got);
      vertex_t exp_v;
      if (pending.size() == 0) begin
        $error("result with no item outstanding: x=%h y=%h z=%h", got.x, got.y, got.z);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      checked++;
      if (got.scaled) scaled_seen++;
      if (got.x !== exp_v.x) begin
        $error("out_x: expected %h, got %h", exp_v.x, got.x);
        errors++;
      end
      if (got.y !== exp_v.y) begin
        $error("out_y: expected %h, got %h", exp_v.y, got.y);
        errors++;
      end
      if (got.z !== exp_v.z) begin
        $error("out_z: expected %h, got %h", exp_v.z, got.z);
        errors++;
      end
      if (got.scaled !== exp_v.scaled) begin
        $error("was_scaled: expected %b, got %b", exp_v.scaled, got.scaled);
        errors++;
      end
      if (got.last !== exp_v.last) begin
        $error("out_last: expected %b, got %b", exp_v.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int Latency    = 97;
  localparam int PhaseItems = 370;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CoordW-1:0] pos_x_i = '0;
  logic [CoordW-1:0] pos_y_i = '0;
  logic [CoordW-1:0] pos_z_i = '0;
  logic              in_last_i = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [0:0]        cfg_idx_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              done_o;
  logic [CoordW-1:0] out_x_o;
  logic [CoordW-1:0] out_y_o;
  logic [CoordW-1:0] out_z_o;
  logic              was_scaled_o;
  logic              out_last_o;

  vertex_scoreboard vertex_sb = new();
  int               items_sent;
  bit               allow_idle;

  radial_sqrt_vertex_compress DUT (
    .clk_i, .rst_ni, .start, .busy,
    .pos_x_i, .pos_y_i, .pos_z_i, .in_last_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .out_x_o, .out_y_o, .out_z_o, .was_scaled_o, .out_last_o
  );

  always #5 clk_i = ~clk_i;

  // Record every accepted item and check every strobed result at the edge
  // that accepts it; inputs only move on the falling edge, so no race here.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      vertex_sb.note_item(pos_x_i, pos_y_i, pos_z_i, in_last_i);
    end
    if (rst_ni && done_o) begin
      vertex_sb.check_result({out_x_o, out_y_o, out_z_o, was_scaled_o, out_last_o});
    end
  end

  // Write one register; the predictor follows at the same edge.
  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    vertex_sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_data_i = CfgW'($urandom());
  endtask

  // Present one vertex and hold it until the block takes it. Start stays high
  // into the next item unless an idle burst is drawn.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      start = 1'b0;
      repeat (gap) begin
        pos_x_i = $urandom();
        @(negedge clk_i);
      end
    end
    start     = 1'b1;
    pos_x_i   = x;
    pos_y_i   = y;
    pos_z_i   = z;
    in_last_i = last;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Mix full-range coordinates with small ones, which land near the threshold.
  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: v = $urandom_range(0, 1 << 20);
      3: v = $urandom_range(0, 1 << 10);
      4: v = $urandom_range(0, 200);
      default: v = 32'(vertex_sb.min_r) + $urandom_range(0, 4) - 2;
    endcase
    if (v != 32'h8000_0000 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic random_vertices(int count);
    logic [31:0] x, y, z;
    repeat (count) begin
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      // Single-axis vertices probe the threshold exactly.
      if ($urandom_range(0, 7) == 0) begin
        y = '0;
        z = '0;
      end
      send_vertex(x, y, z, $urandom_range(0, 7) == 0);
    end
  endtask

  // Drop start, then drain the pipe before touching registers again.
  task automatic wait_drained();
    start = 1'b0;
    while (vertex_sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    allow_idle = 1'b1;

    // Directed items under reset defaults: zero, threshold edges, extremes.
    send_vertex(32'd0, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd66, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd67, 32'd0, 32'd0, 1'b1);
    send_vertex(-32'sd67, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd0, -32'sd66, 32'd0, 1'b1);
    send_vertex(32'd0, 32'd0, 32'd68, 1'b0);
    send_vertex(32'd38, 32'd38, 32'd38, 1'b0);
    send_vertex(32'h0001_0000, 32'd0, 32'd0, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0);
    send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b1);
    send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 1'b0);
    random_vertices(PhaseItems);
    wait_drained();

    // Largest gain and threshold: big vertices saturate, small ones pass.
    write_reg(REG_SCALE_GAIN, 24'hFF_FFFF);
    write_reg(REG_MIN_RADIUS, 24'h00_FFFF);
    send_vertex(32'h0000_FFFF, 32'd0, 32'd0, 1'b0);
    send_vertex(32'h0001_0000, 32'd0, 32'd0, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    random_vertices(PhaseItems);
    wait_drained();

    // Zero gain and zero threshold: every nonzero vertex collapses to origin.
    write_reg(REG_SCALE_GAIN, 24'd0);
    write_reg(REG_MIN_RADIUS, 24'd0);
    send_vertex(32'd1, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd0, 32'd0, 32'd0, 1'b1);
    random_vertices(PhaseItems);
    wait_drained();

    // Unit gain with a random threshold, then both random.
    write_reg(REG_SCALE_GAIN, 24'h01_0000);
    write_reg(REG_MIN_RADIUS, CfgW'($urandom_range(0, 16'hFFFF)));
    random_vertices(PhaseItems);
    wait_drained();

    write_reg(REG_SCALE_GAIN, CfgW'($urandom_range(0, 24'hFF_FFFF)));
    write_reg(REG_MIN_RADIUS, CfgW'($urandom_range(0, 16'hFFFF)));
    // Last stretch back to back, no gaps.
    allow_idle = 1'b0;
    random_vertices(PhaseItems);
    start = 1'b0;

    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    $display("Sent %0d vertices over five register settings; %0d results checked, %0d scaled.",
             items_sent, vertex_sb.checked, vertex_sb.scaled_seen);
    if (vertex_sb.errors == 0 && vertex_sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rsvc_pkg.sv
hw/rtl/radial_sqrt_vertex_compress.sv
dv/radial_sqrt_vertex_compress_test.sv
